// File: rtl/xps_pkg.sv
// xps_pkg: shared types, constants and seeding function for the xorwow generator.
// Used by xps_step and xorwow_prng_seeded_core. No dependencies.
package xps_pkg;

   // Field widths
   localparam int unsigned WORD_W = 32;
   localparam int unsigned SEED_W = 64;

   // Weyl sequence increment applied on every step
   localparam logic [WORD_W-1:0] WEYL_STEP = WORD_W'(362437);

   // Silent steps run after every reseed (and after reset)
   localparam int unsigned WARMUP_STEPS = 64;
   localparam int unsigned WARM_CNT_W   = $clog2(WARMUP_STEPS + 1);
   localparam logic [WARM_CNT_W-1:0] WARM_LOAD = WARM_CNT_W'(WARMUP_STEPS);

   // Action codes
   typedef enum logic {
      ACT_NEXT   = 1'b0,
      ACT_RESEED = 1'b1
   } action_type;

   // Complete generator state: five xorshift words and the Weyl addend
   typedef struct packed {
      logic [WORD_W-1:0] word_a;
      logic [WORD_W-1:0] word_b;
      logic [WORD_W-1:0] word_c;
      logic [WORD_W-1:0] word_d;
      logic [WORD_W-1:0] word_e;
      logic [WORD_W-1:0] weyl_addend;
   } gen_state_type;

   // State straight after loading a seed, before the warm-up steps
   function automatic gen_state_type seed_state(input logic [SEED_W-1:0] seed);
      gen_state_type s;
      s.word_a      = seed[WORD_W-1:0];
      s.word_b      = seed[SEED_W-1:WORD_W];
      s.word_c      = '0;
      s.word_d      = '0;
      s.word_e      = ~seed[WORD_W-1:0];
      s.weyl_addend = (seed[WORD_W-1:0] << 10) ^ (seed[SEED_W-1:WORD_W] >> 4);
      return s;
   endfunction

endpackage

// File: rtl/xorwow_prng_seeded_core.sv
// xorwow_prng_seeded_core: xorwow generator with Weyl addend and 64-bit reseed.
// A request waits in the input register, executes in the execute stage and its
// result is held in the result register; warm-up or a stalled result stalls it.
// Throughput: one request per cycle while no warm-up runs and the result
// channel does not stall; a reseed holds the execute stage for its silent
// warm-up steps; one further transaction may wait in the input register.
// Reset: synchronous; loads the seed-zero state and runs the same warm-up.
// Depends on xps_pkg and xps_step.
module xorwow_prng_seeded_core
   import xps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [SEED_W-1:0] req_seed,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_random_value
);

   logic                  in_vld_ff,  in_vld_in;
   logic                  in_act_ff,  in_act_in;
   logic [SEED_W-1:0]     in_seed_ff, in_seed_in;
   gen_state_type         gen_ff,     gen_in;
   logic [WARM_CNT_W-1:0] warm_cnt_ff, warm_cnt_in;
   logic                  out_vld_ff, out_vld_in;
   logic [WORD_W-1:0]     out_val_ff, out_val_in;

   gen_state_type         step_state;
   logic [WORD_W-1:0]     step_value;
   logic                  warm_busy;
   logic                  out_free;
   logic                  exec_fire;
   logic                  exec_next;
   logic                  exec_reseed;

   xps_step u_step (
      .cur_state (gen_ff),
      .nxt_state (step_state),
      .value     (step_value)
   );

   // Execute-stage control
   assign warm_busy   = warm_cnt_ff != '0;
   assign out_free    = !out_vld_ff || rsp_ready;
   assign exec_fire   = in_vld_ff && !warm_busy &&
                        (in_act_ff == ACT_RESEED || out_free);
   assign exec_next   = exec_fire && in_act_ff == ACT_NEXT;
   assign exec_reseed = exec_fire && in_act_ff == ACT_RESEED;
   assign req_ready   = !in_vld_ff || exec_fire;

   // Input register
   always_comb begin
      in_vld_in  = in_vld_ff && !exec_fire;
      in_act_in  = in_act_ff;
      in_seed_in = in_seed_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_act_in  = req_action;
         in_seed_in = req_seed;
      end
   end

   // Generator state and warm-up counter
   always_comb begin
      gen_in      = gen_ff;
      warm_cnt_in = warm_cnt_ff;
      if (warm_busy) begin
         gen_in      = step_state;
         warm_cnt_in = warm_cnt_ff - 1'b1;
      end else if (exec_reseed) begin
         gen_in      = seed_state(in_seed_ff);
         warm_cnt_in = WARM_LOAD;
      end else if (exec_next) begin
         gen_in = step_state;
      end
   end

   // Result register
   always_comb begin
      out_vld_in = out_vld_ff && !rsp_ready;
      out_val_in = out_val_ff;
      if (exec_next) begin
         out_vld_in = 1'b1;
         out_val_in = step_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         gen_ff      <= seed_state('0);
         warm_cnt_ff <= WARM_LOAD;
         out_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         gen_ff      <= gen_in;
         warm_cnt_ff <= warm_cnt_in;
         out_vld_ff  <= out_vld_in;
      end
      in_act_ff  <= in_act_in;
      in_seed_ff <= in_seed_in;
      out_val_ff <= out_val_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_random_value = out_val_ff;

   // Nothing executes while warm-up is running
   a_no_exec_in_warmup: assert property (@(posedge clock) disable iff (reset)
      warm_busy |-> !exec_fire)
      else $error("transaction executed during warm-up");

   // A reseed always reloads the full warm-up count
   a_reseed_loads_count: assert property (@(posedge clock) disable iff (reset)
      exec_reseed |=> warm_cnt_ff == WARM_LOAD)
      else $error("warm-up count not loaded on reseed");

   // A new result appears only after a request executed
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(exec_next))
      else $error("result without a request");

   // The xorshift words never collapse to all zero
   a_state_nonzero: assert property (@(posedge clock) disable iff (reset)
      (gen_ff.word_a | gen_ff.word_b | gen_ff.word_c | gen_ff.word_d |
       gen_ff.word_e) != '0)
      else $error("xorshift state all zero");

endmodule

// File: rtl/xps_step.sv
// xps_step: one combinational xorwow step plus Weyl addend update.
// Depends on xps_pkg.
module xps_step
   import xps_pkg::*;
(
   input  gen_state_type     cur_state,
   output gen_state_type     nxt_state,
   output logic [WORD_W-1:0] value
);

   logic [WORD_W-1:0] t_pre;
   logic [WORD_W-1:0] t_new;
   logic [WORD_W-1:0] addend_new;

   // xorshift on the oldest word, mixed with the newest
   assign t_pre = cur_state.word_a ^ (cur_state.word_a >> 2);
   assign t_new = t_pre ^ (t_pre << 1) ^ cur_state.word_e ^ (cur_state.word_e << 4);
   assign addend_new = cur_state.weyl_addend + WEYL_STEP;

   // Shift the word queue along
   always_comb begin
      nxt_state.word_a      = cur_state.word_b;
      nxt_state.word_b      = cur_state.word_c;
      nxt_state.word_c      = cur_state.word_d;
      nxt_state.word_d      = cur_state.word_e;
      nxt_state.word_e      = t_new;
      nxt_state.weyl_addend = addend_new;
   end

   assign value = t_new + addend_new;

endmodule

// File: dv/tb.sv
// tb: self-checking testbench for xorwow_prng_seeded_core. It predicts each
// random number locally and checks it against the result channel.
// Depends on xps_pkg (widths, Weyl step, warm-up count, action codes) and the core RTL.
`timescale 1ns / 100ps

module tb;
   import xps_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned IDLE_PCT    = 28;
   localparam int unsigned TAIL_CYCLES = WARMUP_STEPS + 16;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_action = ACT_NEXT;
   logic [SEED_W-1:0] req_seed = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_random_value;

   // Local generator state: five xorshift words and the Weyl sum
   logic [WORD_W-1:0] xs_word [5];
   logic [WORD_W-1:0] weyl_sum;

   logic [WORD_W-1:0] expected_numbers [$];
   bit                gaps_enabled = 1'b1;
   int                output_hold_cycles = 0;
   int                mismatch_count = 0;
   int unsigned       cycle_count = 0;

   xorwow_prng_seeded_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_seed         (req_seed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

   // Clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // One xorwow step on the local state; returns the number it yields
   function automatic logic [WORD_W-1:0] step_generator();
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] last;
      t    = xs_word[0];
      last = xs_word[4];
      t    = t ^ (t >> 2);
      t    = t ^ (t << 1) ^ last ^ (last << 4);
      xs_word[0] = xs_word[1];
      xs_word[1] = xs_word[2];
      xs_word[2] = xs_word[3];
      xs_word[3] = last;
      xs_word[4] = t;
      weyl_sum   = weyl_sum + WEYL_STEP;
      return t + weyl_sum;
   endfunction

   // Load a 64-bit seed, then run the silent warm-up steps
   function automatic void reseed_generator(input logic [SEED_W-1:0] seed);
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      lo = seed[WORD_W-1:0];
      hi = seed[SEED_W-1:WORD_W];
      xs_word[0] = lo;
      xs_word[1] = hi;
      xs_word[2] = '0;
      xs_word[3] = '0;
      xs_word[4] = ~lo;
      weyl_sum   = (lo << 10) ^ (hi >> 4);
      for (int i = 0; i < WARMUP_STEPS; i++)
         void'(step_generator());
   endfunction

   // Receiver: random back-pressure, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (output_hold_cycles > 0) begin
         output_hold_cycles <= output_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !gaps_enabled || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Result checker: each transaction against the oldest expected number
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_numbers.size() == 0) begin
            $error("random_value: no result expected, actual %h", rsp_random_value);
            mismatch_count++;
         end else begin
            logic [WORD_W-1:0] want;
            want = expected_numbers.pop_front();
            if (rsp_random_value !== want) begin
               $error("random_value mismatch: expected %h, actual %h",
                      want, rsp_random_value);
               mismatch_count++;
            end
         end
      end
   end

   // Send one transaction; called and returning at a falling edge.
   // Valid is left high so a following call can keep it asserted.
   task automatic send_item(input action_type act, input logic [SEED_W-1:0] seed);
      while (gaps_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_seed   <= seed;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (act == ACT_RESEED)
         reseed_generator(seed);
      else
         expected_numbers.push_back(step_generator());
      @(negedge clock);
   endtask

   // Sender pause until every expected number has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_numbers.size() != 0)
         @(negedge clock);
   endtask

   // State after reset must match a zero seed with warm-up
   task automatic test_reset_state();
      repeat (3) send_item(ACT_NEXT, '0);
      wait_drained();
   endtask

   // Extreme seeds, including zero whose complement keeps the state non-zero
   task automatic test_seed_extremes();
      send_item(ACT_RESEED, 64'h0);
      repeat (2) send_item(ACT_NEXT, '0);
      send_item(ACT_RESEED, '1);
      send_item(ACT_NEXT, '0);
      send_item(ACT_RESEED, 64'hFFFF_FFFF_0000_0000);
      send_item(ACT_NEXT, '0);
      send_item(ACT_RESEED, 64'h0000_0000_FFFF_FFFF);
      send_item(ACT_NEXT, '0);
      send_item(ACT_RESEED, 64'h8000_0000_0000_0001);
      send_item(ACT_NEXT, '0);
      wait_drained();
   endtask

   // Seed field must be ignored on a request
   task automatic test_ignored_seed();
      send_item(ACT_NEXT, '1);
      send_item(ACT_NEXT, {$urandom, $urandom});
      send_item(ACT_NEXT, 64'hA5A5_A5A5_5A5A_5A5A);
      wait_drained();
   endtask

   // Reseeds back to back, one landing while the previous warm-up runs
   task automatic test_back_to_back_reseeds();
      send_item(ACT_RESEED, 64'h0123_4567_89AB_CDEF);
      send_item(ACT_RESEED, 64'hFEDC_BA98_7654_3210);
      send_item(ACT_NEXT, '0);
      send_item(ACT_RESEED, 64'h5555_5555_AAAA_AAAA);
      send_item(ACT_NEXT, '0);
      wait_drained();
   endtask

   // Long receiver hold-off while requests keep coming, so the input stalls
   task automatic test_output_stall();
      output_hold_cycles = 300;
      repeat (30) send_item(ACT_NEXT, {$urandom, $urandom});
      wait_drained();
   endtask

   // Random mix of requests and reseeds
   task automatic test_random_traffic(input int count);
      logic [SEED_W-1:0] seed;
      for (int i = 0; i < count; i++) begin
         seed = {$urandom, $urandom};
         if ($urandom_range(0, 99) < 15) begin
            // occasionally force a half of the seed to an extreme
            case ($urandom_range(0, 7))
               0: seed[WORD_W-1:0] = '0;
               1: seed[SEED_W-1:WORD_W] = '0;
               2: seed[WORD_W-1:0] = '1;
               3: seed[SEED_W-1:WORD_W] = '1;
               default: ;
            endcase
            send_item(ACT_RESEED, seed);
         end else begin
            send_item(ACT_NEXT, seed);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      reseed_generator('0);
      @(negedge clock);

      test_reset_state();
      test_seed_extremes();
      test_ignored_seed();
      test_back_to_back_reseeds();
      test_output_stall();

      test_random_traffic(500);
      gaps_enabled = 1'b0;
      test_random_traffic(350);
      wait_drained();
      gaps_enabled = 1'b1;
      test_random_traffic(550);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
